// ===== sv/clt_pkg.sv =====
// Shared types and constants for the command line tokenizer.
package clt_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_IN_ARG,
    PH_BETWEEN
  } phase_t;

  typedef enum logic [1:0] {
    CFG_MAX_ARG_LENGTH = 2'd0,
    CFG_MAX_ARG_COUNT  = 2'd1,
    CFG_ECHO_ENABLE    = 2'd2
  } cfg_index_t;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  localparam logic [5:0] ARG_LENGTH_MAX     = 6'd63;
  localparam logic [5:0] DEF_MAX_ARG_LENGTH = 6'd32;
  localparam logic [4:0] DEF_MAX_ARG_COUNT  = 5'd16;
  localparam logic       DEF_ECHO_ENABLE    = 1'b1;

endpackage

// ===== sv/clt_parser.sv =====
// Parse state and per-byte result logic of the tokenizer.
module clt_parser #(
  parameter int SLOTS        = 8,
  parameter int BUFFER_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [7:0]                      rx_byte,
  input  logic [5:0]                      max_arg_length,
  input  logic [4:0]                      max_arg_count,
  output logic [7:0]                      echo_char,
  output logic [$clog2(BUFFER_BYTES)-1:0] byte_pos,
  output logic                            nul_here,
  output logic                            arg_begin,
  output logic [4:0]                      arg_slot,
  output logic                            cmd_done,
  output logic [$clog2(SLOTS)-1:0]        cmd_slot,
  output logic [4:0]                      cmd_argc,
  output logic                            cmd_error,
  output logic                            last
);

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam int SW = $clog2(SLOTS);
  localparam logic [PW:0] POS_WRAP  = BUFFER_BYTES[PW:0];
  localparam logic [SW:0] SLOT_WRAP = SLOTS[SW:0];

  clt_pkg::phase_t phase, phase_next;
  logic [4:0]      arg_count, arg_count_next;
  logic [5:0]      arg_length, arg_length_next;
  logic            error_flag, error_flag_next;
  logic [SW-1:0]   slot_index, slot_index_next;
  logic [PW-1:0]   byte_position, byte_position_next;

  logic            is_space;
  logic            is_blank;
  logic            line_end;
  logic            too_long;
  logic [5:0]      count_inc;
  logic [PW:0]     pos_inc;
  logic [SW:0]     slot_inc;

  assign is_space = (rx_byte == clt_pkg::CHAR_SPACE);
  assign is_blank = is_space || (rx_byte >= clt_pkg::CHAR_TAB && rx_byte <= clt_pkg::CHAR_CR);
  assign line_end = (phase != clt_pkg::PH_IDLE) &&
                    (rx_byte == clt_pkg::CHAR_LF || rx_byte == clt_pkg::CHAR_CR);
  assign too_long = (arg_length > max_arg_length);
  assign count_inc = {1'b0, arg_count} + 6'd1;
  assign pos_inc   = {1'b0, byte_position} + {{PW{1'b0}}, 1'b1};
  assign slot_inc  = {1'b0, slot_index} + {{SW{1'b0}}, 1'b1};

  always_comb begin
    phase_next         = phase;
    arg_count_next     = arg_count;
    arg_length_next    = arg_length;
    error_flag_next    = error_flag;
    slot_index_next    = slot_index;
    byte_position_next = (pos_inc == POS_WRAP) ? '0 : pos_inc[PW-1:0];

    echo_char = rx_byte;
    byte_pos  = byte_position;
    nul_here  = 1'b0;
    arg_begin = 1'b0;
    arg_slot  = '0;
    cmd_done  = 1'b0;
    cmd_slot  = '0;
    cmd_argc  = '0;
    cmd_error = 1'b0;
    last      = 1'b1;

    if (line_end) begin
      // CR word carries the command; the LF word follows from the output queue
      error_flag_next = error_flag | too_long;
      echo_char       = clt_pkg::CHAR_CR;
      nul_here        = 1'b1;
      cmd_done        = 1'b1;
      cmd_slot        = slot_index;
      cmd_argc        = arg_count;
      cmd_error       = error_flag | too_long;
      last            = 1'b0;
      slot_index_next = (slot_inc == SLOT_WRAP) ? '0 : slot_inc[SW-1:0];
      phase_next      = clt_pkg::PH_IDLE;
    end else begin
      unique case (phase)
        clt_pkg::PH_IN_ARG: begin
          if (!is_space) begin
            if (arg_length < clt_pkg::ARG_LENGTH_MAX) arg_length_next = arg_length + 6'd1;
          end else begin
            if (too_long) error_flag_next = 1'b1;
            nul_here   = 1'b1;
            phase_next = clt_pkg::PH_BETWEEN;
          end
        end
        clt_pkg::PH_BETWEEN: begin
          if (!is_space) begin
            arg_begin = 1'b1;
            arg_slot  = arg_count;
            if (count_inc > {1'b0, max_arg_count}) begin
              error_flag_next = 1'b1;
              arg_count_next  = '0;
            end else begin
              arg_count_next = count_inc[4:0];
            end
            arg_length_next = 6'd1;
            phase_next      = clt_pkg::PH_IN_ARG;
          end
        end
        default: begin
          if (!is_blank) begin
            arg_begin       = 1'b1;
            arg_count_next  = 5'd1;
            error_flag_next = 1'b0;
            arg_length_next = 6'd1;
            phase_next      = clt_pkg::PH_IN_ARG;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= clt_pkg::PH_IDLE;
      arg_count     <= '0;
      arg_length    <= '0;
      error_flag    <= 1'b0;
      slot_index    <= '0;
      byte_position <= '0;
    end else if (step) begin
      phase         <= phase_next;
      arg_count     <= arg_count_next;
      arg_length    <= arg_length_next;
      error_flag    <= error_flag_next;
      slot_index    <= slot_index_next;
      byte_position <= byte_position_next;
    end
  end

endmodule

// ===== sv/command_line_tokenizer.sv =====
// An accepted byte's first result word is registered into the output register, or into
// the skid register while the output register holds a word. One byte per cycle is taken
// while rx_stall is low; a line end inside a command gives two words (CR, LF). A two-word
// queue keeps input open while one result word waits. cfg_ready is always high.
// Reset clears parse state, position, slot, queue and restores register defaults.
module command_line_tokenizer #(
  parameter int SLOTS        = 8,
  parameter int BUFFER_BYTES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rx_valid,
  output logic                            rx_stall,
  input  logic [7:0]                      rx_byte,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [7:0]                      echo_char,
  output logic                            echo_valid,
  output logic [$clog2(BUFFER_BYTES)-1:0] byte_pos,
  output logic                            nul_here,
  output logic                            arg_begin,
  output logic [4:0]                      arg_slot,
  output logic                            cmd_done,
  output logic [$clog2(SLOTS)-1:0]        cmd_slot,
  output logic [4:0]                      cmd_argc,
  output logic                            cmd_error,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [5:0]                      cfg_data
);

  localparam int PW = $clog2(BUFFER_BYTES);
  localparam int SW = $clog2(SLOTS);

  typedef struct packed {
    logic [7:0]    echo_char;
    logic          echo_valid;
    logic [PW-1:0] byte_pos;
    logic          nul_here;
    logic          arg_begin;
    logic [4:0]    arg_slot;
    logic          cmd_done;
    logic [SW-1:0] cmd_slot;
    logic [4:0]    cmd_argc;
    logic          cmd_error;
    logic          last;
  } word_t;

  logic [5:0] max_arg_length;
  logic [4:0] max_arg_count;
  logic       echo_enable;

  word_t  new_word;
  word_t  main_word;
  word_t  skid_word;
  logic   main_v;
  logic   skid_v;
  logic   accept;
  logic   take;
  logic   pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_arg_length <= clt_pkg::DEF_MAX_ARG_LENGTH;
      max_arg_count  <= clt_pkg::DEF_MAX_ARG_COUNT;
      echo_enable    <= clt_pkg::DEF_ECHO_ENABLE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clt_pkg::CFG_MAX_ARG_LENGTH: max_arg_length <= cfg_data;
        clt_pkg::CFG_MAX_ARG_COUNT:  max_arg_count  <= cfg_data[4:0];
        clt_pkg::CFG_ECHO_ENABLE:    echo_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign rx_stall = skid_v;
  assign accept   = rx_valid && !rx_stall;
  assign take     = main_v && !res_stall;
  // a CR word stays in place and turns into its LF word
  assign pop      = take && main_word.last;

  clt_parser #(
    .SLOTS        (SLOTS),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .rx_byte        (rx_byte),
    .max_arg_length (max_arg_length),
    .max_arg_count  (max_arg_count),
    .echo_char      (new_word.echo_char),
    .byte_pos       (new_word.byte_pos),
    .nul_here       (new_word.nul_here),
    .arg_begin      (new_word.arg_begin),
    .arg_slot       (new_word.arg_slot),
    .cmd_done       (new_word.cmd_done),
    .cmd_slot       (new_word.cmd_slot),
    .cmd_argc       (new_word.cmd_argc),
    .cmd_error      (new_word.cmd_error),
    .last           (new_word.last)
  );

  assign new_word.echo_valid = echo_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      priority if (take && !main_word.last) begin
        main_word.echo_char <= clt_pkg::CHAR_LF;
        main_word.nul_here  <= 1'b0;
        main_word.cmd_done  <= 1'b0;
        main_word.cmd_slot  <= '0;
        main_word.cmd_argc  <= '0;
        main_word.cmd_error <= 1'b0;
        main_word.last      <= 1'b1;
        if (accept) begin
          skid_word <= new_word;
          skid_v    <= 1'b1;
        end
      end else if (pop || !main_v) begin
        if (skid_v) begin
          main_word <= skid_word;
          main_v    <= 1'b1;
          skid_v    <= 1'b0;
        end else if (accept) begin
          main_word <= new_word;
          main_v    <= 1'b1;
        end else begin
          main_v <= 1'b0;
        end
      end else begin
        if (accept) begin
          skid_word <= new_word;
          skid_v    <= 1'b1;
        end
      end
    end
  end

  assign res_valid  = main_v;
  assign echo_char  = main_word.echo_char;
  assign echo_valid = main_word.echo_valid;
  assign byte_pos   = main_word.byte_pos;
  assign nul_here   = main_word.nul_here;
  assign arg_begin  = main_word.arg_begin;
  assign arg_slot   = main_word.arg_slot;
  assign cmd_done   = main_word.cmd_done;
  assign cmd_slot   = main_word.cmd_slot;
  assign cmd_argc   = main_word.cmd_argc;
  assign cmd_error  = main_word.cmd_error;
  assign last       = main_word.last;

`ifndef SYNTH
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> main_v)
    else $error("skid word held while output register empty");

  a_first_is_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !last) |-> (cmd_done && nul_here && echo_char == clt_pkg::CHAR_CR))
    else $error("first of a word pair is not a command completion");

  a_lf_follows: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !last) |=>
      (res_valid && last && echo_char == clt_pkg::CHAR_LF && !cmd_done && !nul_here))
    else $error("LF word did not follow CR word");

  a_done_no_begin: assert property (@(posedge clk) disable iff (rst)
    (res_valid && cmd_done) |-> !arg_begin)
    else $error("command completion also starts an argument");
`endif

endmodule
